[hw/rtl/e2q_pkg.sv]
package e2q_pkg;

   localparam int ANGLE_W = 18;
   localparam int QUAT_W = 32;
   localparam int TABLE_LEN = 30;
   localparam int CW = 34;
   localparam longint ANGLE_LIMIT = 92160;
   localparam longint PI_Q30 = 64'd3373259426;
   localparam longint HALF_PI_Q30 = 64'd1686629713;
   localparam longint INV_GAIN_Q30 = 64'd652032874;
   localparam longint ONE_Q30 = 64'd1073741824;

   // PI_Q30 = PI_DIV_Q * 92160 + PI_DIV_R, and 92160 = 2048 * 45.
   localparam int PI_DIV_Q = 36602;
   localparam int PI_DIV_R = 19106;
   localparam int ROUND_HALF = 46080;
   // Reciprocal of 45 with 26 fraction bits, exact for 20-bit dividends.
   localparam int RECIP_45 = 1491309;

   typedef logic signed [CW-1:0] cordic_type;
   typedef logic signed [31:0] q30_type;

   typedef struct packed {
      cordic_type x;
      cordic_type y;
      cordic_type z;
      logic flip;
   } cell_type;

   function automatic cordic_type atan_q30(input int i);
      case (i)
         0: atan_q30 = 34'sd843314856;
         1: atan_q30 = 34'sd497837829;
         2: atan_q30 = 34'sd263043836;
         3: atan_q30 = 34'sd133525158;
         4: atan_q30 = 34'sd67021686;
         5: atan_q30 = 34'sd33543515;
         6: atan_q30 = 34'sd16775850;
         7: atan_q30 = 34'sd8388437;
         8: atan_q30 = 34'sd4194282;
         9: atan_q30 = 34'sd2097149;
         10: atan_q30 = 34'sd1048575;
         11: atan_q30 = 34'sd524287;
         12: atan_q30 = 34'sd262143;
         13: atan_q30 = 34'sd131071;
         14: atan_q30 = 34'sd65535;
         15: atan_q30 = 34'sd32767;
         16: atan_q30 = 34'sd16383;
         17: atan_q30 = 34'sd8191;
         18: atan_q30 = 34'sd4095;
         19: atan_q30 = 34'sd2047;
         20: atan_q30 = 34'sd1023;
         21: atan_q30 = 34'sd511;
         22: atan_q30 = 34'sd255;
         23: atan_q30 = 34'sd127;
         24: atan_q30 = 34'sd63;
         25: atan_q30 = 34'sd31;
         26: atan_q30 = 34'sd15;
         27: atan_q30 = 34'sd8;
         28: atan_q30 = 34'sd4;
         29: atan_q30 = 34'sd2;
         default: atan_q30 = '0;
      endcase
   endfunction

   function automatic q30_type sat_q30(input logic signed [63:0] v);
      if (v > ONE_Q30) begin
         sat_q30 = 32'sd1073741824;
      end else if (v < -ONE_Q30) begin
         sat_q30 = -32'sd1073741824;
      end else begin
         sat_q30 = q30_type'(v);
      end
   endfunction

   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd536870912;
      mul_q30 = q30_type'(p >>> 30);
   endfunction

endpackage

[hw/rtl/e2q_cell.sv]
module e2q_cell
   import e2q_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic valid_in,
   input  logic enable,
   input  cell_type data_in,
   output logic valid_out,
   output cell_type data_out
);

   cell_type data_ff, data_in_w;
   logic valid_ff;

   always_comb begin
      data_in_w = data_in;
      if (data_in.z >= 0) begin
         data_in_w.x = data_in.x - (data_in.y >>> STAGE);
         data_in_w.y = data_in.y + (data_in.x >>> STAGE);
         data_in_w.z = data_in.z - atan_q30(STAGE);
      end else begin
         data_in_w.x = data_in.x + (data_in.y >>> STAGE);
         data_in_w.y = data_in.y - (data_in.x >>> STAGE);
         data_in_w.z = data_in.z + atan_q30(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         data_ff <= data_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign data_out = data_ff;

endmodule

[hw/rtl/e2q_sincos.sv]
module e2q_sincos
   import e2q_pkg::*;
#(
   parameter int STAGES = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic valid_in,
   input  logic signed [ANGLE_W-1:0] angle,
   output logic valid_out,
   output q30_type sin_out,
   output q30_type cos_out
);

   localparam int N = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;

   cell_type head_ff, head_in;
   logic head_valid_ff;
   logic pre_valid_ff;
   logic neg_ff, neg_in;
   logic [31:0] base_ff, base_in;
   logic [30:0] rem_ff, rem_in;
   cell_type chain [0:N];
   logic chain_v [0:N];
   logic signed [63:0] a, th, z;
   logic [ANGLE_W-2:0] mag;
   logic [40:0] rem_prod;

   always_comb begin
      a = 64'(angle);
      if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
      if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
      neg_in = (a < 0);
      mag = (ANGLE_W-1)'((a < 0) ? -a : a);
      base_in = 32'(mag) * 32'(PI_DIV_Q);
      rem_in = 31'(32'(mag) * 32'(PI_DIV_R) + 32'(ROUND_HALF));
   end

   always_comb begin
      rem_prod = 41'(rem_ff[30:11]) * 41'(RECIP_45);
      th = 64'(base_ff) + 64'(rem_prod[40:26]);
      z = neg_ff ? -th : th;
      head_in.flip = 1'b0;
      if (z > HALF_PI_Q30) begin
         z = z - PI_Q30;
         head_in.flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z = z + PI_Q30;
         head_in.flip = 1'b1;
      end
      head_in.x = cordic_type'(INV_GAIN_Q30);
      head_in.y = '0;
      head_in.z = cordic_type'(z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
         head_valid_ff <= 1'b0;
      end else if (enable) begin
         pre_valid_ff <= valid_in;
         head_valid_ff <= pre_valid_ff;
      end
      if (enable) begin
         neg_ff <= neg_in;
         base_ff <= base_in;
         rem_ff <= rem_in;
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;
   assign chain_v[0] = head_valid_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      e2q_cell #(.STAGE(i)) u_cell (
         .clock(clock), .reset(reset), .valid_in(chain_v[i]), .enable(enable),
         .data_in(chain[i]), .valid_out(chain_v[i+1]), .data_out(chain[i+1])
      );
   end

   logic signed [CW-1:0] xf, yf;
   assign xf = chain[N].flip ? -chain[N].x : chain[N].x;
   assign yf = chain[N].flip ? -chain[N].y : chain[N].y;
   assign cos_out = sat_q30(64'(xf));
   assign sin_out = sat_q30(64'(yf));
   assign valid_out = chain_v[N];

endmodule

[hw/rtl/euler_to_quaternion.sv]
// Converts Euler angles (z, then x, then y) into a unit quaternion.
// The request word carries three signed angles in degrees with 8
// fraction bits; angles beyond 360 degrees are clamped. The response word
// carries the four components as signed fixed point with OUT_FRAC_BITS
// fraction bits.
// Every stage is a register in one pipeline: two input stages, one CORDIC
// cell per stage (CORDIC_STAGES, at most 30), two product stages and one
// output stage. A new word is accepted every cycle while the receiver does
// not stall.
// When the receiver stalls, the whole pipeline holds and req_ready falls,
// so no word is lost; ready is high whenever the output stage is empty or
// being drained. Reset empties the pipeline; no state carries across
// words.
module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int CORDIC_STAGES = 24,
   parameter int OUT_FRAC_BITS = 30
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [ANGLE_W-1:0] req_x_angle,
   input  logic signed [ANGLE_W-1:0] req_y_angle,
   input  logic signed [ANGLE_W-1:0] req_z_angle,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [QUAT_W-1:0] rsp_quat_x,
   output logic signed [QUAT_W-1:0] rsp_quat_y,
   output logic signed [QUAT_W-1:0] rsp_quat_z,
   output logic signed [QUAT_W-1:0] rsp_quat_w
);

   localparam int SH = 30 - OUT_FRAC_BITS;

   logic enable, vx, vy, vz;
   q30_type sx, cx, sy, cy, sz, cz;

   assign enable = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   e2q_sincos #(.STAGES(CORDIC_STAGES)) u_x (.clock(clock), .reset(reset),
      .enable(enable), .valid_in(req_valid), .angle(req_x_angle),
      .valid_out(vx), .sin_out(sx), .cos_out(cx));
   e2q_sincos #(.STAGES(CORDIC_STAGES)) u_y (.clock(clock), .reset(reset),
      .enable(enable), .valid_in(req_valid), .angle(req_y_angle),
      .valid_out(vy), .sin_out(sy), .cos_out(cy));
   e2q_sincos #(.STAGES(CORDIC_STAGES)) u_z (.clock(clock), .reset(reset),
      .enable(enable), .valid_in(req_valid), .angle(req_z_angle),
      .valid_out(vz), .sin_out(sz), .cos_out(cz));

   q30_type p_ff, q_ff, r_ff, t_ff, sz_ff, cz_ff;
   q30_type ox_ff, oy_ff, oz_ff, ow_ff;
   logic v1_ff, v2_ff, vo_ff;
   logic signed [QUAT_W-1:0] fx_ff, fy_ff, fz_ff, fw_ff;

   function automatic logic signed [QUAT_W-1:0] to_out(input q30_type v);
      logic signed [63:0] r;
      r = 64'(v);
      if (SH > 0) r = (r + (64'sd1 <<< (SH - 1))) >>> SH;
      if (r > (64'sd1 <<< OUT_FRAC_BITS)) r = 64'sd1 <<< OUT_FRAC_BITS;
      if (r < -(64'sd1 <<< OUT_FRAC_BITS)) r = -(64'sd1 <<< OUT_FRAC_BITS);
      to_out = QUAT_W'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= vx;
         v2_ff <= v1_ff;
         vo_ff <= v2_ff;
      end
      if (enable) begin
         p_ff <= mul_q30(cy, sx);
         q_ff <= mul_q30(cx, sy);
         r_ff <= -mul_q30(sx, sy);
         t_ff <= mul_q30(cy, cx);
         sz_ff <= sz;
         cz_ff <= cz;
         ox_ff <= sat_q30(64'(mul_q30(q_ff, sz_ff)) + 64'(mul_q30(p_ff, cz_ff)));
         oy_ff <= sat_q30(64'(mul_q30(q_ff, cz_ff)) - 64'(mul_q30(p_ff, sz_ff)));
         oz_ff <= sat_q30(64'(mul_q30(r_ff, cz_ff)) + 64'(mul_q30(t_ff, sz_ff)));
         ow_ff <= sat_q30(64'(mul_q30(t_ff, cz_ff)) - 64'(mul_q30(r_ff, sz_ff)));
         fx_ff <= to_out(ox_ff);
         fy_ff <= to_out(oy_ff);
         fz_ff <= to_out(oz_ff);
         fw_ff <= to_out(ow_ff);
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_quat_x = fx_ff;
   assign rsp_quat_y = fy_ff;
   assign rsp_quat_z = fz_ff;
   assign rsp_quat_w = fw_ff;

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      (vx == vy) && (vy == vz)) else $error("sincos lanes out of step");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_w))
      else $error("response word changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("ready low with empty output");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import e2q_pkg::*;

   localparam int STAGES = 24;
   localparam int FRAC_BITS = 30;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      longint c[4];
   } quat_word;

   class quat_scoreboard;
      quat_word pending_q[$];
      int errors;
      int matched;

      function longint clamp(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function longint qmul(longint a, longint b);
         return (a * b + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function void half_sin_cos(logic signed [ANGLE_W-1:0] raw, output longint s,
                                 output longint c);
         longint a, mag, th, x, y, z, xs, ys;
         bit flip;
         a = clamp(longint'(raw), ANGLE_LIMIT);
         mag = (a < 0) ? -a : a;
         th = (mag * PI_Q30 + 46080) / 92160;
         z = (a < 0) ? -th : th;
         x = INV_GAIN_Q30;
         y = 0;
         flip = 0;
         if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = 1;
         end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            flip = 1;
         end
         for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys;
               y += xs;
               z -= longint'(atan_q30(i));
            end else begin
               x += ys;
               y -= xs;
               z += longint'(atan_q30(i));
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         c = clamp(x, ONE_Q30);
         s = clamp(y, ONE_Q30);
      endfunction

      function longint scale_out(longint v);
         int sh;
         longint r;
         sh = 30 - FRAC_BITS;
         r = v;
         if (sh > 0) r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
         return clamp(r, 64'sd1 <<< FRAC_BITS);
      endfunction

      function void note_angles(logic signed [ANGLE_W-1:0] ax, logic signed [ANGLE_W-1:0] ay,
                                logic signed [ANGLE_W-1:0] az);
         longint sx, cx, sy, cy, sz, cz, p, q, r, t;
         quat_word w;
         half_sin_cos(ax, sx, cx);
         half_sin_cos(ay, sy, cy);
         half_sin_cos(az, sz, cz);
         p = qmul(cy, sx);
         q = qmul(cx, sy);
         r = -qmul(sx, sy);
         t = qmul(cy, cx);
         w.c[0] = scale_out(clamp(qmul(q, sz) + qmul(p, cz), ONE_Q30));
         w.c[1] = scale_out(clamp(qmul(q, cz) - qmul(p, sz), ONE_Q30));
         w.c[2] = scale_out(clamp(qmul(r, cz) + qmul(t, sz), ONE_Q30));
         w.c[3] = scale_out(clamp(qmul(t, cz) - qmul(r, sz), ONE_Q30));
         pending_q.push_back(w);
      endfunction

      function void check_quat(logic signed [QUAT_W-1:0] got[4]);
         quat_word w;
         string names[4] = '{"quat_x", "quat_y", "quat_z", "quat_w"};
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected response word", $time);
            errors++;
            return;
         end
         w = pending_q.pop_front();
         for (int i = 0; i < 4; i++) begin
            if (got[i] !== QUAT_W'(w.c[i])) begin
               $display("%0t: %s expected %0d actual %0d", $time, names[i], w.c[i], got[i]);
               errors++;
            end
         end
         matched++;
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [ANGLE_W-1:0] req_x_angle;
   logic signed [ANGLE_W-1:0] req_y_angle;
   logic signed [ANGLE_W-1:0] req_z_angle;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [QUAT_W-1:0] rsp_quat_x;
   logic signed [QUAT_W-1:0] rsp_quat_y;
   logic signed [QUAT_W-1:0] rsp_quat_z;
   logic signed [QUAT_W-1:0] rsp_quat_w;

   quat_scoreboard board;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   longint cycles;
   int sent;

   euler_to_quaternion dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_x_angle(req_x_angle),
      .req_y_angle(req_y_angle),
      .req_z_angle(req_z_angle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y),
      .rsp_quat_z(rsp_quat_z),
      .rsp_quat_w(rsp_quat_w)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      logic signed [QUAT_W-1:0] got[4];
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready) board.note_angles(req_x_angle, req_y_angle, req_z_angle);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w};
            board.check_quat(got);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_angles(logic signed [ANGLE_W-1:0] ax, logic signed [ANGLE_W-1:0] ay,
                              logic signed [ANGLE_W-1:0] az);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_x_angle <= ax;
      req_y_angle <= ay;
      req_z_angle <= az;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(negedge clock);
      while (board.pending_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      int k;
      k = $urandom_range(99);
      if (k < 65) return ANGLE_W'($signed($urandom_range(184320)) - 92160);
      if (k < 80) return ANGLE_W'($urandom);
      case ($urandom_range(7))
         0: return 0;
         1: return 92160;
         2: return -92160;
         3: return ANGLE_W'(46080 + $signed($urandom_range(4)) - 2);
         4: return ANGLE_W'(-46080 + $signed($urandom_range(4)) - 2);
         5: return 23040;
         6: return -23040;
         default: return ANGLE_W'(92160 + $urandom_range(1000));
      endcase
   endfunction

   task automatic random_block(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) send_angles(pick_angle(), pick_angle(), pick_angle());
   endtask

   initial begin
      logic signed [ANGLE_W-1:0] dir[$];
      board = new();
      cycles = 0;
      sent = 0;
      hold_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1;
      req_valid = 0;
      req_x_angle = 0;
      req_y_angle = 0;
      req_z_angle = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      dir = '{0, 92160, -92160, 92161, -92161, 131071, -131072, 46080, 46081, -46080,
              -46081, 23040, -23040, 1, -1};
      foreach (dir[i]) send_angles(dir[i], dir[(i + 3) % dir.size()], dir[(i + 7) % dir.size()]);
      send_angles(23040, 0, 0);
      send_angles(0, 23040, 0);
      send_angles(0, 0, 23040);
      send_angles(92160, 92160, 92160);
      send_angles(-131072, -131072, -131072);
      drain();

      random_block(250, 0, 0);
      random_block(220, 82, 0);
      random_block(220, 0, 82);
      random_block(220, 36, 36);
      hold_cycles = 300;
      random_block(120, 0, 0);
      drain();
      random_block(120, 0, 0);
      drain();

      repeat (60) @(negedge clock);
      $display("Sent %0d angle triples (directed limits, clamping, fold points, random);",
               sent);
      $display("checked %0d quaternion words under four idle/stall mixes and a long hold.",
               board.matched);
      if (board.errors == 0 && board.pending_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
